[src/agkf_pkg.sv]
// Package for the angle/gyro Kalman filter: fixed-point constants, register
// indexes, datapath opcodes and the controller-to-datapath command struct.
// No dependencies.
package agkf_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_ANGLE_QN  = 3'd1;
  localparam logic [2:0] REG_BIAS_QN   = 3'd2;
  localparam logic [2:0] REG_MEAS_R    = 3'd3;
  localparam logic [2:0] REG_OBS_GAIN  = 3'd4;

  localparam logic [15:0] RST_TIME_STEP = 16'd66;
  localparam logic [30:0] RST_ANGLE_QN  = 31'd66;
  localparam logic [30:0] RST_BIAS_QN   = 31'd328;
  localparam logic [30:0] RST_MEAS_R    = 31'd32768;
  localparam logic signed [31:0] RST_OBS_GAIN = 32'sd65536;

  // Datapath micro-operations, one per controller step.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_RC,      // rc = sat(rate - bias)
    OP_MRC,     // m = fx(rc*dt)
    OP_ANG1,    // angle = sat(angle + m)
    OP_ERR,     // err = sat(meas - angle)
    OP_D0,      // d0 = sat(Qa - p01 - p10)
    OP_MD0,     // m = fx(d0*dt)
    OP_P00A,    // p00 = sat(p00 + m)
    OP_MDP,     // m = fx(p11*dt)
    OP_P01A,    // p01 -= m, p10 -= m
    OP_MQG,     // m = fx(Qg*dt)
    OP_P11A,    // p11 += m
    OP_MA,      // a = fx(g*p00)
    OP_MB,      // b = fx(g*p10)
    OP_MGA,     // m = fx(g*a)
    OP_E,       // e = sat(R + m)
    OP_DIVK0,   // start a/e
    OP_DIVK1,   // k0 = quotient, start b/e
    OP_K1,      // k1 = quotient
    OP_MT,      // t = fx(g*p01)
    OP_MK0A,    // m = fx(k0*a)
    OP_P00B,
    OP_MK0T,
    OP_P01B,
    OP_MK1A,
    OP_P10B,
    OP_MK1T,
    OP_P11B,
    OP_MK0E,
    OP_ANG2,
    OP_MK1E,
    OP_BIAS
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;   // capture input beat
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh7fffffff) r = S32_MAX;
    else if (v < -66'sh80000000) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[src/angle_gyro_kalman_filter.sv]
// Two-state Kalman filter (angle and gyro bias) on Q16.16 samples.
// Input channel: in_measured_angle, in_measured_rate with in_valid/in_ready.
// Output channel: out_fused_angle, out_corrected_rate with out_valid/out_ready.
// Config: APB-style port, registers at 4*i: time_step, angle_process_noise,
// bias_process_noise, measurement_noise, observation_gain; reads return them.
// One beat at a time: after acceptance the controller steps one shared
// 32x32 multiplier through the update and runs the gains on a radix-2
// divider of 48 steps per gain, waiting on the divider for each gain;
// out_valid rises once the bias update, the last datapath step, is done.
// A new beat is accepted only after the result has been taken; the
// divider's 48 iterations per gain and output stall time set the rate.
// in_ready is low while a beat is in work or its result waits; a stalled
// receiver holds out_valid and the result until it is taken.
// Reset (rst_n, synchronous) clears the estimates, sets the covariance to
// identity and the registers to their defaults.
module angle_gyro_kalman_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_measured_angle,
  input  logic signed [31:0] in_measured_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_fused_angle,
  output logic signed [31:0] out_corrected_rate,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [15:0]        dt_r;
  logic [30:0]        qa_r, qg_r, rn_r;
  logic signed [31:0] g_r;
  logic [2:0]         idx;
  agkf_pkg::dp_cmd_t  cmd;
  agkf_pkg::dp_sts_t  sts;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= agkf_pkg::RST_TIME_STEP;
      qa_r <= agkf_pkg::RST_ANGLE_QN;
      qg_r <= agkf_pkg::RST_BIAS_QN;
      rn_r <= agkf_pkg::RST_MEAS_R;
      g_r  <= agkf_pkg::RST_OBS_GAIN;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (idx)
        agkf_pkg::REG_TIME_STEP: dt_r <= cfg_pwdata[15:0];
        agkf_pkg::REG_ANGLE_QN:  qa_r <= cfg_pwdata[30:0];
        agkf_pkg::REG_BIAS_QN:   qg_r <= cfg_pwdata[30:0];
        agkf_pkg::REG_MEAS_R:    rn_r <= cfg_pwdata[30:0];
        agkf_pkg::REG_OBS_GAIN:  g_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      agkf_pkg::REG_TIME_STEP: cfg_prdata = {16'd0, dt_r};
      agkf_pkg::REG_ANGLE_QN:  cfg_prdata = {1'b0, qa_r};
      agkf_pkg::REG_BIAS_QN:   cfg_prdata = {1'b0, qg_r};
      agkf_pkg::REG_MEAS_R:    cfg_prdata = {1'b0, rn_r};
      agkf_pkg::REG_OBS_GAIN:  cfg_prdata = g_r;
      default:                 cfg_prdata = '0;
    endcase
  end

  agkf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  agkf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_meas   (in_measured_angle),
    .in_rate   (in_measured_rate),
    .dt        (dt_r),
    .qa        (qa_r),
    .qg        (qg_r),
    .rn        (rn_r),
    .g         (g_r),
    .angle     (out_fused_angle),
    .rate_corr (out_corrected_rate)
  );

endmodule

[src/agkf_div.sv]
// Radix-2 restoring divider: sat((n << FRAC_BITS) / d), truncating toward zero.
// Depends on agkf_pkg.
module agkf_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [31:0]  num,
  input  logic signed [31:0]  den,
  output logic                busy,
  output logic signed [31:0]  quot
);

  localparam int NW = 32 + agkf_pkg::FRAC_BITS;

  logic [NW-1:0]  n_r, n_nxt;      // shifting dividend / quotient
  logic [32:0]    rem_r, rem_nxt;
  logic [31:0]    d_r, d_nxt;
  logic           neg_r, neg_nxt;
  logic           zero_r, zero_nxt;
  logic           nsgn_r, nsgn_nxt;
  logic           nz_r, nz_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic [32:0]    trial;
  logic [33:0]    diff;
  logic [NW:0]    qs;

  always_comb begin
    n_nxt = n_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r; zero_nxt = zero_r;
    nsgn_nxt = nsgn_r; nz_nxt = nz_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r[31:0], n_r[NW-1]};
    diff = {1'b0, trial} - {2'b00, d_r};
    if (start) begin
      n_nxt = NW'(num[31] ? -{{agkf_pkg::FRAC_BITS{num[31]}}, num} :
                           {{agkf_pkg::FRAC_BITS{1'b0}}, num}) << agkf_pkg::FRAC_BITS;
      d_nxt = den[31] ? 32'(-den) : den;
      rem_nxt = '0;
      neg_nxt = num[31] ^ den[31];
      zero_nxt = (den == 0);
      nsgn_nxt = num[31];
      nz_nxt = (num != 0);
      cnt_nxt = 6'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_nxt = diff[32:0];
        n_nxt = {n_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        n_nxt = {n_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r <= n_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
    zero_r <= zero_nxt; nsgn_r <= nsgn_nxt; nz_r <= nz_nxt;
  end

  always_comb begin
    qs = neg_r ? -{1'b0, n_r} : {1'b0, n_r};
    if (zero_r) quot = !nz_r ? 32'sd0 : (nsgn_r ? agkf_pkg::S32_MIN : agkf_pkg::S32_MAX);
    else quot = agkf_pkg::sat32(66'($signed(qs)));
  end

  assign busy = busy_r;

endmodule

[src/agkf_datapath.sv]
// Datapath: state and covariance registers, one shared multiplier with a
// registered product, adder/saturator, and the gain divider. Depends on agkf_pkg.
module agkf_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  agkf_pkg::dp_cmd_t     cmd,
  output agkf_pkg::dp_sts_t     sts,
  input  logic signed [31:0]    in_meas,
  input  logic signed [31:0]    in_rate,
  input  logic [15:0]           dt,
  input  logic [30:0]           qa,
  input  logic [30:0]           qg,
  input  logic [30:0]           rn,
  input  logic signed [31:0]    g,
  output logic signed [31:0]    angle,
  output logic signed [31:0]    rate_corr
);

  logic signed [31:0] ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [31:0] p00_r, p00_nxt, p01_r, p01_nxt, p10_r, p10_nxt, p11_r, p11_nxt;
  logic signed [31:0] meas_r, rate_r, rc_r, err_r, d0_r, a_r, b_r, e_r, k0_r, k1_r, t_r, m_r;
  logic signed [31:0] rc_nxt, err_nxt, d0_nxt, a_nxt, b_nxt, e_nxt, k0_nxt, k1_nxt, t_nxt, m_nxt;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] fxp;
  logic               div_start, div_busy;
  logic signed [31:0] div_num, div_q;
  logic signed [31:0] dts;

  assign dts = $signed({16'd0, dt});

  always_comb begin
    ma = '0; mb = '0;
    case (cmd.op)
      agkf_pkg::OP_MRC:  begin ma = rc_r;  mb = dts; end
      agkf_pkg::OP_MD0:  begin ma = d0_r;  mb = dts; end
      agkf_pkg::OP_MDP:  begin ma = p11_r; mb = dts; end
      agkf_pkg::OP_MQG:  begin ma = $signed({1'b0, qg}); mb = dts; end
      agkf_pkg::OP_MA:   begin ma = g; mb = p00_r; end
      agkf_pkg::OP_MB:   begin ma = g; mb = p10_r; end
      agkf_pkg::OP_MGA:  begin ma = g; mb = a_r; end
      agkf_pkg::OP_MT:   begin ma = g; mb = p01_r; end
      agkf_pkg::OP_MK0A: begin ma = k0_r; mb = a_r; end
      agkf_pkg::OP_MK0T: begin ma = k0_r; mb = t_r; end
      agkf_pkg::OP_MK1A: begin ma = k1_r; mb = a_r; end
      agkf_pkg::OP_MK1T: begin ma = k1_r; mb = t_r; end
      agkf_pkg::OP_MK0E: begin ma = k0_r; mb = err_r; end
      agkf_pkg::OP_MK1E: begin ma = k1_r; mb = err_r; end
      default: ;
    endcase
    prod = ma * mb;
    // arithmetic shift floors, matching round toward minus infinity
    fxp = agkf_pkg::sat32(66'(prod >>> agkf_pkg::FRAC_BITS));
  end

  always_comb begin
    ang_nxt = ang_r; bias_nxt = bias_r;
    p00_nxt = p00_r; p01_nxt = p01_r; p10_nxt = p10_r; p11_nxt = p11_r;
    rc_nxt = rc_r; err_nxt = err_r; d0_nxt = d0_r; a_nxt = a_r; b_nxt = b_r;
    e_nxt = e_r; k0_nxt = k0_r; k1_nxt = k1_r; t_nxt = t_r; m_nxt = fxp;
    div_start = 1'b0; div_num = a_r;
    case (cmd.op)
      agkf_pkg::OP_RC:   rc_nxt = agkf_pkg::sat32(66'(rate_r) - 66'(bias_r));
      agkf_pkg::OP_ANG1: ang_nxt = agkf_pkg::sat32(66'(ang_r) + 66'(m_r));
      agkf_pkg::OP_ERR:  err_nxt = agkf_pkg::sat32(66'(meas_r) - 66'(ang_r));
      agkf_pkg::OP_D0:   d0_nxt = agkf_pkg::sat32(66'($signed({1'b0, qa})) - 66'(p01_r)
                                                  - 66'(p10_r));
      agkf_pkg::OP_P00A: p00_nxt = agkf_pkg::sat32(66'(p00_r) + 66'(m_r));
      agkf_pkg::OP_P01A: begin
        p01_nxt = agkf_pkg::sat32(66'(p01_r) - 66'(m_r));
        p10_nxt = agkf_pkg::sat32(66'(p10_r) - 66'(m_r));
      end
      agkf_pkg::OP_P11A: p11_nxt = agkf_pkg::sat32(66'(p11_r) + 66'(m_r));
      agkf_pkg::OP_MA:   a_nxt = fxp;
      agkf_pkg::OP_MB:   b_nxt = fxp;
      agkf_pkg::OP_E:    e_nxt = agkf_pkg::sat32(66'($signed({1'b0, rn})) + 66'(m_r));
      agkf_pkg::OP_DIVK0: div_start = 1'b1;
      agkf_pkg::OP_DIVK1: begin
        k0_nxt = div_q; div_start = 1'b1; div_num = b_r;
      end
      agkf_pkg::OP_K1:   k1_nxt = div_q;
      agkf_pkg::OP_MT:   t_nxt = fxp;
      agkf_pkg::OP_P00B: p00_nxt = agkf_pkg::sat32(66'(p00_r) - 66'(m_r));
      agkf_pkg::OP_P01B: p01_nxt = agkf_pkg::sat32(66'(p01_r) - 66'(m_r));
      agkf_pkg::OP_P10B: p10_nxt = agkf_pkg::sat32(66'(p10_r) - 66'(m_r));
      agkf_pkg::OP_P11B: p11_nxt = agkf_pkg::sat32(66'(p11_r) - 66'(m_r));
      agkf_pkg::OP_ANG2: ang_nxt = agkf_pkg::sat32(66'(ang_r) + 66'(m_r));
      agkf_pkg::OP_BIAS: bias_nxt = agkf_pkg::sat32(66'(bias_r) + 66'(m_r));
      default: ;
    endcase
  end

  agkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (e_r),
    .busy  (div_busy),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r <= '0; bias_r <= '0;
      p00_r <= agkf_pkg::FX_ONE; p01_r <= '0; p10_r <= '0; p11_r <= agkf_pkg::FX_ONE;
    end else begin
      ang_r <= ang_nxt; bias_r <= bias_nxt;
      p00_r <= p00_nxt; p01_r <= p01_nxt; p10_r <= p10_nxt; p11_r <= p11_nxt;
    end
    if (cmd.load) begin
      meas_r <= in_meas;
      rate_r <= in_rate;
    end
    rc_r <= rc_nxt; err_r <= err_nxt; d0_r <= d0_nxt; a_r <= a_nxt; b_r <= b_nxt;
    e_r <= e_nxt; k0_r <= k0_nxt; k1_r <= k1_nxt; t_r <= t_nxt; m_r <= m_nxt;
  end

  assign sts.div_busy = div_busy;
  assign angle = ang_r;
  assign rate_corr = agkf_pkg::sat32(66'(rate_r) - 66'(bias_r));

endmodule

[src/agkf_ctrl.sv]
// Controller: sequences datapath operations per beat and runs the handshakes.
// Depends on agkf_pkg.
module agkf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output agkf_pkg::dp_cmd_t  cmd,
  input  agkf_pkg::dp_sts_t  sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t        st_r, st_nxt;
  agkf_pkg::op_t op_r, op_nxt;

  always_comb begin
    st_nxt = st_r;
    op_nxt = op_r;
    cmd.load = 1'b0;
    cmd.op = agkf_pkg::OP_NOP;
    in_ready = (st_r == S_IDLE);
    out_valid = (st_r == S_OUT);
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt = S_RUN;
          op_nxt = agkf_pkg::OP_RC;
        end
      end
      S_RUN: begin
        cmd.op = op_r;
        if (op_r == agkf_pkg::OP_BIAS) st_nxt = S_OUT;
        else if (op_r == agkf_pkg::OP_DIVK0 || op_r == agkf_pkg::OP_DIVK1) begin
          st_nxt = S_WAIT;
          op_nxt = agkf_pkg::op_t'(op_r + 5'd1);
        end else op_nxt = agkf_pkg::op_t'(op_r + 5'd1);
      end
      S_WAIT: begin
        // hold until the divider has the quotient
        if (!sts.div_busy) st_nxt = S_RUN;
      end
      S_OUT: begin
        if (out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      op_r <= agkf_pkg::OP_NOP;
    end else begin
      st_r <= st_nxt;
      op_r <= op_nxt;
    end
  end

endmodule

[src/agkf_checker.sv]
// Port-level checker for angle_gyro_kalman_filter, bound to the top level.
// Depends on nothing but the top level's ports.
module agkf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_fused_angle
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result without latency");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_fused_angle)))
    else $error("result dropped under stall");

  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready) else $error("not ready after result");

endmodule

bind angle_gyro_kalman_filter agkf_checker u_agkf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_fused_angle (out_fused_angle)
);

[tb/tb_top.sv]
// Self-checking bench for the angle/gyro Kalman filter: drives angle/rate
// beats, predicts fused angle and corrected rate in Q16.16, checks each beat.
// Depends on agkf_pkg and angle_gyro_kalman_filter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
    logic               known;   // expected result typed in below
    logic signed [31:0] x_angle;
    logic signed [31:0] x_rate;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } fused_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_measured_angle = '0;
  logic signed [31:0] in_measured_rate = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_fused_angle;
  logic signed [31:0] out_corrected_rate;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  angle_gyro_kalman_filter i_dut (.*);

  always #5 clk = ~clk;

  // predictor state and register copies
  longint kf_dt, kf_qa, kf_qg, kf_r, kf_g;
  longint kf_angle, kf_bias;
  longint kf_p[4];

  fused_t fused_q[$];
  int errors = 0;
  int n_beats = 0;
  int n_checked = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat(p >>> agkf_pkg::FRAC_BITS);  // arithmetic shift floors
  endfunction

  function automatic longint qdiv(longint n, longint d);
    if (d == 0) return (n > 0) ? 64'sd2147483647 : (n < 0) ? -64'sd2147483648 : 0;
    return sat((n <<< agkf_pkg::FRAC_BITS) / d);
  endfunction

  task automatic kf_reset();
    kf_dt = 66; kf_qa = 66; kf_qg = 328; kf_r = 32768; kf_g = 65536;
    kf_angle = 0; kf_bias = 0;
    kf_p[0] = 65536; kf_p[1] = 0; kf_p[2] = 0; kf_p[3] = 65536;
  endtask

  function automatic fused_t kf_update(logic signed [31:0] meas_in,
                                       logic signed [31:0] rate_in);
    longint meas, rate, rc, err, d0, dp, a, b, e, k0, k1, t;
    longint p00, p01, p10, p11;
    fused_t r;
    meas = meas_in; rate = rate_in;
    p00 = kf_p[0]; p01 = kf_p[1]; p10 = kf_p[2]; p11 = kf_p[3];
    rc = sat(rate - kf_bias);
    kf_angle = sat(kf_angle + qmul(rc, kf_dt));
    err = sat(meas - kf_angle);
    d0 = sat(kf_qa - p01 - p10);
    dp = qmul(p11, kf_dt);
    p00 = sat(p00 + qmul(d0, kf_dt));
    p01 = sat(p01 - dp);
    p10 = sat(p10 - dp);
    p11 = sat(p11 + qmul(kf_qg, kf_dt));
    a = qmul(kf_g, p00);
    b = qmul(kf_g, p10);
    e = sat(kf_r + qmul(kf_g, a));
    k0 = qdiv(a, e);
    k1 = qdiv(b, e);
    t = qmul(kf_g, p01);
    p00 = sat(p00 - qmul(k0, a));
    p01 = sat(p01 - qmul(k0, t));
    p10 = sat(p10 - qmul(k1, a));
    p11 = sat(p11 - qmul(k1, t));
    kf_p[0] = p00; kf_p[1] = p01; kf_p[2] = p10; kf_p[3] = p11;
    kf_angle = sat(kf_angle + qmul(k0, err));
    kf_bias = sat(kf_bias + qmul(k1, err));
    r.angle = kf_angle[31:0];
    r.rate = 32'(sat(rate - kf_bias));
    return r;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      agkf_pkg::REG_TIME_STEP: kf_dt = value[15:0];
      agkf_pkg::REG_ANGLE_QN:  kf_qa = value[30:0];
      agkf_pkg::REG_BIAS_QN:   kf_qg = value[30:0];
      agkf_pkg::REG_MEAS_R:    kf_r = value[30:0];
      agkf_pkg::REG_OBS_GAIN:  kf_g = $signed(value);
      default: ;
    endcase
    // leave the bus idle between transfers
    @(negedge clk);
  endtask

  task automatic set_filter(logic [31:0] dt, logic [31:0] qa, logic [31:0] qg,
                            logic [31:0] r, logic [31:0] g);
    reg_write(agkf_pkg::REG_TIME_STEP, dt);
    reg_write(agkf_pkg::REG_ANGLE_QN, qa);
    reg_write(agkf_pkg::REG_BIAS_QN, qg);
    reg_write(agkf_pkg::REG_MEAS_R, r);
    reg_write(agkf_pkg::REG_OBS_GAIN, g);
  endtask

  // wait for the pipeline to drain, plus the block's latency
  task automatic drain();
    while (fused_q.size() != 0) @(negedge clk);
    repeat (160) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_sample(int mode);
    case (mode)
      0: return $signed($urandom);
      1: return $signed($urandom_range(0, 131072)) - 65536;
      2: return $signed($urandom_range(0, 2000000)) - 1000000;
      default: return ($urandom_range(0, 1) != 0) ? agkf_pkg::S32_MAX : agkf_pkg::S32_MIN;
    endcase
  endfunction

  task automatic send_beat(logic signed [31:0] ang, logic signed [31:0] rt,
                           bit known, logic signed [31:0] xa, logic signed [31:0] xr);
    fused_t f;
    in_valid <= 1'b1;
    in_measured_angle <= ang;
    in_measured_rate <= rt;
    do @(posedge clk); while (!in_ready);
    f = kf_update(ang, rt);
    if (known && (f.angle !== xa || f.rate !== xr)) begin
      $error("predictor table row: expected %0d/%0d, model %0d/%0d", xa, xr, f.angle, f.rate);
      errors++;
    end
    if (known) begin
      f.angle = xa;
      f.rate = xr;
    end
    fused_q.push_back(f);
    n_beats++;
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4))
        @(negedge clk);
    end
  endtask

  stim_row_t dir_rows[$];

  initial begin
    stim_row_t row;
    int mode;
    kf_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // first beat from reset: zero in, zero out is exact
    row = '{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0}; dir_rows.push_back(row);
    row = '{agkf_pkg::S32_MAX, agkf_pkg::S32_MAX, 1'b0, 0, 0}; dir_rows.push_back(row);
    row = '{agkf_pkg::S32_MIN, agkf_pkg::S32_MIN, 1'b0, 0, 0}; dir_rows.push_back(row);
    row = '{agkf_pkg::S32_MAX, agkf_pkg::S32_MIN, 1'b0, 0, 0}; dir_rows.push_back(row);
    row = '{agkf_pkg::S32_MIN, agkf_pkg::S32_MAX, 1'b0, 0, 0}; dir_rows.push_back(row);
    row = '{32'sd65536, -32'sd65536, 1'b0, 0, 0}; dir_rows.push_back(row);
    row = '{-32'sd1, 32'sd1, 1'b0, 0, 0}; dir_rows.push_back(row);
    row = '{32'sh55555555, 32'shaaaaaaaa, 1'b0, 0, 0}; dir_rows.push_back(row);
    row = '{32'shaaaaaaaa, 32'sh55555555, 1'b0, 0, 0}; dir_rows.push_back(row);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].angle, dir_rows[i].rate, dir_rows[i].known,
                dir_rows[i].x_angle, dir_rows[i].x_rate);
    in_valid <= 1'b0;
    drain();

    // zero measurement noise and zero gain: innovation variance hits zero
    set_filter(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < 4; i++) send_beat(rand_sample(0), rand_sample(0), 0, 0, 0);
    in_valid <= 1'b0;
    drain();
    // negative gain, extreme registers
    set_filter(32'hffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    for (int i = 0; i < 6; i++) send_beat(rand_sample(3), rand_sample(0), 0, 0, 0);
    in_valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: set_filter(32'd66, 32'd66, 32'd328, 32'd32768, 32'd65536);
        1: set_filter($urandom_range(1, 65535), $urandom & 32'h7fffffff,
                      $urandom & 32'h7fffffff, $urandom_range(1, 32'h7fffffff), $urandom);
        2: set_filter($urandom_range(1, 2000), $urandom_range(0, 5000),
                      $urandom_range(0, 5000), $urandom_range(1, 100000),
                      $signed($urandom_range(0, 262144)) - 131072);
        default: set_filter(32'd1, 32'd0, 32'd0, 32'd1, 32'h7fffffff);
      endcase
      if (phase == 2) hold_off = 1'b1;
      for (int i = 0; i < 170; i++) begin
        mode = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 2) : $urandom_range(0, 3);
        send_beat(rand_sample(mode), rand_sample(mode), 0, 0, 0);
      end
      in_valid <= 1'b0;
      drain();
    end
    stim_done = 1'b1;
  end

  // receiver: random stalls plus one long hold-off while the sender waits
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_ready <= 1'b0;
        repeat (2000) @(negedge clk);
      end
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 3);
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fused_t x;
    if (rst_n && out_valid && out_ready) begin
      if (fused_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        x = fused_q.pop_front();
        n_checked++;
        if (out_fused_angle !== x.angle) begin
          $error("fused_angle: expected %0d, actual %0d", x.angle, out_fused_angle);
          errors++;
        end
        if (out_corrected_rate !== x.rate) begin
          $error("corrected_rate: expected %0d, actual %0d", x.rate, out_corrected_rate);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    if (fused_q.size() != 0) errors++;
    $display("Covered reset defaults, zero innovation variance, extreme and random gains,");
    $display("saturating samples and a long receiver hold-off: %0d beats, %0d checked.",
             n_beats, n_checked);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

[files.f]
src/agkf_pkg.sv
src/agkf_div.sv
src/agkf_datapath.sv
src/agkf_ctrl.sv
src/angle_gyro_kalman_filter.sv
src/agkf_checker.sv
tb/tb_top.sv
